### hdl/counting_semaphore_pool_core_assert.svh
// Assertion helpers for the semaphore pool core.
// Each macro expects clk and rst to be visible where it is used.
`ifndef COUNTING_SEMAPHORE_POOL_CORE_ASSERT_SVH
`define COUNTING_SEMAPHORE_POOL_CORE_ASSERT_SVH

// Same-cycle implication.
`define CSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/csp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csp_pkg
// Shared codes and table access types for the semaphore pool core.
// ----------------------------------------------------------------------------
package csp_pkg;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_PEND   = 2'd2,
    ACT_POST   = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_INVALID      = 4'd1,
    ST_OVERFLOW     = 4'd2,
    ST_ALL_BUSY     = 4'd3,
    ST_HAS_WAITERS  = 4'd4,
    ST_UNAVAILABLE  = 4'd5,
    ST_IN_INTERRUPT = 4'd6,
    ST_LOCKED       = 4'd7,
    ST_BLOCKED      = 4'd8
  } status_t;

  // Semaphore table read view (queue head and tail task ids carried at full 8 bits)
  typedef struct packed {
    logic        in_use;
    logic        q_valid;
    logic [15:0] cnt;
    logic [7:0]  head;
    logic [7:0]  tail;
  } sem_rd_t;

  // Semaphore table update
  typedef struct packed {
    logic [7:0]  idx;
    logic        use_set;
    logic        use_clr;
    logic        cnt_we;
    logic [15:0] cnt;
    logic        q_set;
    logic        q_clr;
    logic        head_we;
    logic [7:0]  head;
    logic        tail_we;
    logic [7:0]  tail;
  } sem_wr_t;

endpackage
`default_nettype wire

### hdl/csp_free_stack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csp_free_stack
// Stack of free semaphore handles; handle 0 sits on top after reset.
// ----------------------------------------------------------------------------
module csp_free_stack #(
  parameter int SEM_SLOTS = 16,
  localparam int SW_OUT   = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 pop,
  input  wire logic                 push,
  input  wire logic [SW_OUT-1:0]    push_handle,
  output logic                      empty,
  output logic [SW_OUT-1:0]         top_handle
);
  localparam int FW     = $clog2(SEM_SLOTS + 1);

  logic [SW_OUT-1:0] stack [SEM_SLOTS];
  logic [FW-1:0]     top;
  logic [FW-1:0]     top_m1;
  logic              full;

  assign top_m1     = top - 1'b1;
  assign empty      = (top == '0);
  assign full       = (top == FW'(SEM_SLOTS));
  assign top_handle = empty ? '0 : stack[top_m1[SW_OUT-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      top <= FW'(SEM_SLOTS);
      for (int i = 0; i < SEM_SLOTS; i++) begin
        stack[i] <= SW_OUT'(SEM_SLOTS - 1 - i);
      end
    end else if (pop && !empty) begin
      top <= top_m1;
    end else if (push && !full) begin
      stack[top[SW_OUT-1:0]] <= push_handle;
      top                    <= top + 1'b1;
    end
  end

endmodule
`default_nettype wire

### hdl/csp_sem_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csp_sem_table
// Per-semaphore state: in-use flag, count and wait queue head/tail.
// ----------------------------------------------------------------------------
module csp_sem_table #(
  parameter int SEM_SLOTS  = 16,
  parameter int TASK_SLOTS = 32,
  localparam int SW        = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1,
  localparam int TW        = $clog2(TASK_SLOTS)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [SW-1:0]    rd_idx,
  output csp_pkg::sem_rd_t      rd,
  input  wire csp_pkg::sem_wr_t wr
);
  logic          in_use  [SEM_SLOTS];
  logic          q_valid [SEM_SLOTS];
  logic [15:0]   cnt     [SEM_SLOTS];
  logic [TW-1:0] head    [SEM_SLOTS];
  logic [TW-1:0] tail    [SEM_SLOTS];
  logic [SW-1:0] widx;

  assign widx = wr.idx[SW-1:0];

  always_comb begin
    rd.in_use  = in_use[rd_idx];
    rd.q_valid = q_valid[rd_idx];
    rd.cnt     = cnt[rd_idx];
    rd.head    = 8'(head[rd_idx]);
    rd.tail    = 8'(tail[rd_idx]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SEM_SLOTS; i++) begin
        in_use[i]  <= 1'b0;
        q_valid[i] <= 1'b0;
      end
    end else begin
      if (wr.use_set) begin
        in_use[widx] <= 1'b1;
      end else if (wr.use_clr) begin
        in_use[widx] <= 1'b0;
      end
      if (wr.q_set) begin
        q_valid[widx] <= 1'b1;
      end else if (wr.q_clr) begin
        q_valid[widx] <= 1'b0;
      end
    end
  end

  // Payload, written before first use
  always_ff @(posedge clk) begin
    if (wr.cnt_we) begin
      cnt[widx] <= wr.cnt;
    end
    if (wr.head_we) begin
      head[widx] <= wr.head[TW-1:0];
    end
    if (wr.tail_we) begin
      tail[widx] <= wr.tail[TW-1:0];
    end
  end

endmodule
`default_nettype wire

### hdl/csp_task_link.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csp_task_link
// Next-waiter links that chain tasks into per-semaphore FIFO queues.
// ----------------------------------------------------------------------------
module csp_task_link #(
  parameter int TASK_SLOTS = 32,
  localparam int TW        = $clog2(TASK_SLOTS)
) (
  input  wire logic          clk,
  input  wire logic [TW-1:0] rd_addr,
  output logic [TW-1:0]      rd_data,
  input  wire logic          we,
  input  wire logic [TW-1:0] wr_addr,
  input  wire logic [TW-1:0] wr_data
);
  logic [TW-1:0] link [TASK_SLOTS];

  assign rd_data = link[rd_addr];

  always_ff @(posedge clk) begin
    if (we) begin
      link[wr_addr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

### hdl/counting_semaphore_pool_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// counting_semaphore_pool_core
// Pool of counting semaphores with FIFO wait queues (create/delete/pend/post).
// ----------------------------------------------------------------------------
// One transaction is taken per clock cycle while results are being taken, and
// its result is presented from the result register: the request is held in an
// input register, a single pass of table lookups and decisions runs against
// the register-held semaphore, free-handle and task-link tables, and the
// outcome lands in the result register at the edge that takes it, while the
// tables are updated at that same edge. A waiting result holds the pass; the
// input register still takes one more request, and in_ready drops only while both registers are full.
// There is no start-up sweep; the block is ready straight out of reset.
module counting_semaphore_pool_core #(
  parameter int SEM_SLOTS   = 16,
  parameter int TASK_SLOTS  = 32,
  parameter int COUNT_LIMIT = 65534
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  handle,
  input  wire logic [15:0] init_count,
  input  wire logic [4:0]  task_id,
  input  wire logic [31:0] timeout,
  input  wire logic        in_interrupt,
  input  wire logic        sched_locked,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       status,
  output logic [7:0]       new_handle,
  output logic             woken_valid,
  output logic [4:0]       woken_task,
  output logic             arm_timer
);
  localparam int SW = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;
  localparam int TW = $clog2(TASK_SLOTS);
  localparam logic [15:0] LIMIT = 16'(COUNT_LIMIT);

  // Task id folding table: entry i holds i mod TASK_SLOTS
  function automatic logic [255:0] build_task_map();
    logic [255:0] m;
    m = '0;
    for (int i = 0; i < 32; i++) begin
      m[i*8 +: 8] = 8'(i % TASK_SLOTS);
    end
    return m;
  endfunction

  localparam logic [255:0] TASK_MAP = build_task_map();

  // Input register
  logic               item_valid;
  csp_pkg::action_t   op_action;
  logic [7:0]         op_handle;
  logic [15:0]        op_init;
  logic [TW-1:0]      op_task;
  logic [31:0]        op_timeout;
  logic               op_intr;
  logic               op_locked;

  // Result register
  csp_pkg::status_t   out_status;
  logic [7:0]         out_handle;
  logic               out_woken;
  logic [4:0]         out_task;
  logic               out_arm;

  logic               advance;
  logic [7:0]         map_idx;
  logic [TW-1:0]      task_folded;

  logic               in_range;
  logic [SW-1:0]      tbl_idx;
  logic               h_ok;
  csp_pkg::sem_rd_t   sem_rd;
  csp_pkg::sem_wr_t   wr_raw;
  csp_pkg::sem_wr_t   sem_wr;
  logic               fs_empty;
  logic [SW-1:0]      fs_head;
  logic               pop_raw;
  logic               push_raw;
  logic               link_we_raw;
  logic [TW-1:0]      link_rd;

  csp_pkg::status_t   st_next;
  logic [7:0]         nh_next;
  logic               wv_next;
  logic [7:0]         wt_next;
  logic               arm_next;

  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  assign map_idx     = {task_id, 3'b000};
  assign task_folded = TW'(TASK_MAP[map_idx +: 8]);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        item_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op_action  <= csp_pkg::action_t'(action);
      op_handle  <= handle;
      op_init    <= init_count;
      op_task    <= task_folded;
      op_timeout <= timeout;
      op_intr    <= in_interrupt;
      op_locked  <= sched_locked;
    end
    if (advance) begin
      out_status <= st_next;
      out_handle <= nh_next;
      out_woken  <= wv_next;
      out_task   <= wt_next[4:0];
      out_arm    <= arm_next;
    end
  end

  assign status      = out_status;
  assign new_handle  = out_handle;
  assign woken_valid = out_woken;
  assign woken_task  = out_task;
  assign arm_timer   = out_arm;

  // Table lookups
  assign in_range = ({1'b0, op_handle} < 9'(SEM_SLOTS));
  assign tbl_idx  = in_range ? op_handle[SW-1:0] : '0;
  assign h_ok     = in_range && sem_rd.in_use;

  csp_sem_table #(
    .SEM_SLOTS  (SEM_SLOTS),
    .TASK_SLOTS (TASK_SLOTS)
  ) u_sem_table (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (tbl_idx),
    .rd     (sem_rd),
    .wr     (sem_wr)
  );

  csp_free_stack #(
    .SEM_SLOTS (SEM_SLOTS)
  ) u_free_stack (
    .clk         (clk),
    .rst         (rst),
    .pop         (pop_raw && advance),
    .push        (push_raw && advance),
    .push_handle (tbl_idx),
    .empty       (fs_empty),
    .top_handle  (fs_head)
  );

  csp_task_link #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_task_link (
    .clk     (clk),
    .rd_addr (sem_rd.head[TW-1:0]),
    .rd_data (link_rd),
    .we      (link_we_raw && advance),
    .wr_addr (sem_rd.tail[TW-1:0]),
    .wr_data (op_task)
  );

  // Decision pass
  always_comb begin
    st_next     = csp_pkg::ST_OK;
    nh_next     = '0;
    wv_next     = 1'b0;
    wt_next     = '0;
    arm_next    = 1'b0;
    pop_raw     = 1'b0;
    push_raw    = 1'b0;
    link_we_raw = 1'b0;
    wr_raw      = '0;
    wr_raw.idx  = 8'(tbl_idx);
    case (op_action)
      csp_pkg::ACT_CREATE: begin
        if (op_init > LIMIT) begin
          st_next = csp_pkg::ST_OVERFLOW;
        end else if (fs_empty) begin
          st_next = csp_pkg::ST_ALL_BUSY;
        end else begin
          pop_raw        = 1'b1;
          nh_next        = 8'(fs_head);
          wr_raw.idx     = 8'(fs_head);
          wr_raw.use_set = 1'b1;
          wr_raw.cnt_we  = 1'b1;
          wr_raw.cnt     = op_init;
          wr_raw.q_clr   = 1'b1;
        end
      end
      csp_pkg::ACT_DELETE: begin
        if (!h_ok) begin
          st_next = csp_pkg::ST_INVALID;
        end else if (sem_rd.q_valid) begin
          st_next = csp_pkg::ST_HAS_WAITERS;
        end else begin
          wr_raw.use_clr = 1'b1;
          push_raw       = 1'b1;
        end
      end
      csp_pkg::ACT_PEND: begin
        if (!h_ok) begin
          st_next = csp_pkg::ST_INVALID;
        end else if (sem_rd.cnt != '0) begin
          wr_raw.cnt_we = 1'b1;
          wr_raw.cnt    = sem_rd.cnt - 16'd1;
        end else if (op_timeout == '0) begin
          st_next = csp_pkg::ST_UNAVAILABLE;
        end else if (op_intr) begin
          st_next = csp_pkg::ST_IN_INTERRUPT;
        end else if (op_locked) begin
          st_next = csp_pkg::ST_LOCKED;
        end else begin
          // append to the tail, or start a fresh queue
          if (sem_rd.q_valid) begin
            link_we_raw = 1'b1;
          end else begin
            wr_raw.q_set   = 1'b1;
            wr_raw.head_we = 1'b1;
            wr_raw.head    = 8'(op_task);
          end
          wr_raw.tail_we = 1'b1;
          wr_raw.tail    = 8'(op_task);
          st_next        = csp_pkg::ST_BLOCKED;
          arm_next       = (op_timeout != '1);
        end
      end
      csp_pkg::ACT_POST: begin
        if (!h_ok) begin
          st_next = csp_pkg::ST_INVALID;
        end else if (sem_rd.cnt == LIMIT) begin
          st_next = csp_pkg::ST_OVERFLOW;
        end else if (sem_rd.q_valid) begin
          wv_next = 1'b1;
          wt_next = sem_rd.head;
          if (sem_rd.head == sem_rd.tail) begin
            wr_raw.q_clr = 1'b1;
          end else begin
            wr_raw.head_we = 1'b1;
            wr_raw.head    = 8'(link_rd);
          end
        end else if (sem_rd.cnt < LIMIT) begin
          wr_raw.cnt_we = 1'b1;
          wr_raw.cnt    = sem_rd.cnt + 16'd1;
        end else begin
          st_next = csp_pkg::ST_OVERFLOW;
        end
      end
      default: begin
        st_next = csp_pkg::ST_INVALID;
      end
    endcase
  end

  // Commit table updates only when the result register takes the transaction
  always_comb begin
    sem_wr         = wr_raw;
    sem_wr.use_set = wr_raw.use_set && advance;
    sem_wr.use_clr = wr_raw.use_clr && advance;
    sem_wr.cnt_we  = wr_raw.cnt_we && advance;
    sem_wr.q_set   = wr_raw.q_set && advance;
    sem_wr.q_clr   = wr_raw.q_clr && advance;
    sem_wr.head_we = wr_raw.head_we && advance;
    sem_wr.tail_we = wr_raw.tail_we && advance;
  end

  `include "counting_semaphore_pool_core_assert.svh"

  `CSP_ASSERT_IMP(a_woken_ok, out_valid && woken_valid, status == csp_pkg::ST_OK, "wake not ok")
  `CSP_ASSERT_IMP(a_arm_blocked, out_valid && arm_timer, status == csp_pkg::ST_BLOCKED, "stray arm")
  `CSP_ASSERT_IMP(a_stall_cause, !in_ready, item_valid && out_valid && !out_ready, "stray stall")
  `CSP_ASSERT_NXT(a_advance_out, advance, out_valid, "committed transaction produced no result")

endmodule
`default_nettype wire

### tb/counting_semaphore_pool_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_pool_core_tb
// Drives create, delete, pend and post transactions into the semaphore pool
// with random idle and stall bursts on both handshakes. A shadow of the pool
// (free stack, counts, wait queues) predicts each result, and every result
// is checked field by field against the oldest prediction still due.
// ----------------------------------------------------------------------------
module counting_semaphore_pool_core_tb;
  import csp_pkg::*;

  localparam int SEM_SLOTS   = 16;
  localparam int TASK_SLOTS  = 32;
  localparam int COUNT_LIMIT = 65534;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    action_t     act;
    logic [7:0]  handle;
    logic [15:0] init_count;
    logic [4:0]  task_id;
    logic [31:0] timeout;
    logic        in_interrupt;
    logic        sched_locked;
  } sem_req_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] new_handle;
    logic       woken_valid;
    logic [4:0] woken_task;
    logic       arm_timer;
  } sem_reply_t;

  class sem_pool_shadow;
    logic [7:0]  free_stack [SEM_SLOTS];
    int          free_top;
    bit          in_use     [SEM_SLOTS];
    logic [15:0] sem_cnt    [SEM_SLOTS];
    bit          q_valid    [SEM_SLOTS];
    logic [4:0]  q_head     [SEM_SLOTS];
    logic [4:0]  q_tail     [SEM_SLOTS];
    logic [4:0]  task_link  [TASK_SLOTS];
    bit          link_set   [TASK_SLOTS];
    sem_reply_t  replies_due[$];
    int          mismatch_count;

    function new();
      int i;
      for (i = 0; i < SEM_SLOTS; i++) begin
        free_stack[i] = 8'(SEM_SLOTS - 1 - i);
        in_use[i]     = 1'b0;
        sem_cnt[i]    = '0;
        q_valid[i]    = 1'b0;
        q_head[i]     = '0;
        q_tail[i]     = '0;
      end
      for (i = 0; i < TASK_SLOTS; i++) begin
        task_link[i] = '0;
        link_set[i]  = 1'b0;
      end
      free_top       = SEM_SLOTS;
      mismatch_count = 0;
    endfunction

    // A post that advances to a task whose link was never written.
    function bit post_reads_unlinked(logic [7:0] h);
      if (h >= SEM_SLOTS || !in_use[h] || !q_valid[h]) return 1'b0;
      if (sem_cnt[h] == COUNT_LIMIT) return 1'b0;
      return q_head[h] != q_tail[h] && !link_set[q_head[h]];
    endfunction

    function sem_reply_t predict_reply(sem_req_t r);
      sem_reply_t y;
      int         h;
      int         s;
      logic [4:0] first;
      y        = '0;
      y.status = ST_OK;
      h        = r.handle;
      if (r.act == ACT_CREATE) begin
        if (r.init_count > COUNT_LIMIT) begin
          y.status = ST_OVERFLOW;
        end else if (free_top == 0) begin
          y.status = ST_ALL_BUSY;
        end else begin
          free_top--;
          s          = free_stack[free_top] % SEM_SLOTS;
          in_use[s]  = 1'b1;
          sem_cnt[s] = r.init_count;
          q_valid[s] = 1'b0;
          y.new_handle = 8'(s);
        end
      end else if (h >= SEM_SLOTS || !in_use[h]) begin
        y.status = ST_INVALID;
      end else if (r.act == ACT_DELETE) begin
        if (q_valid[h]) begin
          y.status = ST_HAS_WAITERS;
        end else begin
          if (free_top < SEM_SLOTS) begin
            free_stack[free_top] = 8'(h);
            free_top++;
          end
          in_use[h] = 1'b0;
        end
      end else if (r.act == ACT_PEND) begin
        if (sem_cnt[h] > 0) begin
          sem_cnt[h]--;
        end else if (r.timeout == 0) begin
          y.status = ST_UNAVAILABLE;
        end else if (r.in_interrupt) begin
          y.status = ST_IN_INTERRUPT;
        end else if (r.sched_locked) begin
          y.status = ST_LOCKED;
        end else begin
          if (q_valid[h]) begin
            task_link[q_tail[h]] = r.task_id;
            link_set[q_tail[h]]  = 1'b1;
          end else begin
            q_valid[h] = 1'b1;
            q_head[h]  = r.task_id;
          end
          q_tail[h]   = r.task_id;
          y.status    = ST_BLOCKED;
          y.arm_timer = r.timeout != '1;
        end
      end else begin
        if (sem_cnt[h] == COUNT_LIMIT) begin
          y.status = ST_OVERFLOW;
        end else if (q_valid[h]) begin
          first         = q_head[h];
          y.woken_valid = 1'b1;
          y.woken_task  = first;
          if (first == q_tail[h]) q_valid[h] = 1'b0;
          else q_head[h] = task_link[first];
        end else begin
          sem_cnt[h]++;
        end
      end
      return y;
    endfunction

    function void note_request(sem_req_t r);
      replies_due.push_back(predict_reply(r));
    endfunction

    function void check_reply(sem_reply_t got);
      sem_reply_t want;
      if (replies_due.size() == 0) begin
        $error("result with none due: status %0d", got.status);
        mismatch_count++;
        return;
      end
      want = replies_due.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatch_count++;
      end
      if (got.new_handle !== want.new_handle) begin
        $error("new_handle: expected %0d, got %0d", want.new_handle, got.new_handle);
        mismatch_count++;
      end
      if (got.woken_valid !== want.woken_valid) begin
        $error("woken_valid: expected %0d, got %0d", want.woken_valid, got.woken_valid);
        mismatch_count++;
      end
      if (got.woken_task !== want.woken_task) begin
        $error("woken_task: expected %0d, got %0d", want.woken_task, got.woken_task);
        mismatch_count++;
      end
      if (got.arm_timer !== want.arm_timer) begin
        $error("arm_timer: expected %0d, got %0d", want.arm_timer, got.arm_timer);
        mismatch_count++;
      end
    endfunction
  endclass

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [1:0]  action       = '0;
  logic [7:0]  handle       = '0;
  logic [15:0] init_count   = '0;
  logic [4:0]  task_id      = '0;
  logic [31:0] timeout      = '0;
  logic        in_interrupt = 1'b0;
  logic        sched_locked = 1'b0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [3:0]  status;
  logic [7:0]  new_handle;
  logic        woken_valid;
  logic [4:0]  woken_task;
  logic        arm_timer;

  sem_pool_shadow shadow = new();
  bit             idle_en = 1'b1;
  int             stall_left = 0;
  int             cycle_count = 0;

  counting_semaphore_pool_core #(
    .SEM_SLOTS   (SEM_SLOTS),
    .TASK_SLOTS  (TASK_SLOTS),
    .COUNT_LIMIT (COUNT_LIMIT)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .handle       (handle),
    .init_count   (init_count),
    .task_id      (task_id),
    .timeout      (timeout),
    .in_interrupt (in_interrupt),
    .sched_locked (sched_locked),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .new_handle   (new_handle),
    .woken_valid  (woken_valid),
    .woken_task   (woken_task),
    .arm_timer    (arm_timer)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: check accepted transactions, stall in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        shadow.check_reply('{status_t'(status), new_handle, woken_valid, woken_task,
                             arm_timer});
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic sem_req_t make_req(action_t act, logic [7:0] h, logic [15:0] cnt,
                                        logic [4:0] tid, logic [31:0] tmo,
                                        logic intr, logic lock);
    sem_req_t r;
    r = '{act, h, cnt, tid, tmo, intr, lock};
    return r;
  endfunction

  // Called just after a rising edge; returns at the edge that takes the transaction.
  task automatic send_req(sem_req_t r);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    action       <= r.act;
    handle       <= r.handle;
    init_count   <= r.init_count;
    task_id      <= r.task_id;
    timeout      <= r.timeout;
    in_interrupt <= r.in_interrupt;
    sched_locked <= r.sched_locked;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
    shadow.note_request(r);
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    while (shadow.replies_due.size() != 0) @(posedge clk);
  endtask

  function automatic sem_req_t random_req(int w_create, int w_delete, int w_pend);
    sem_req_t r;
    int       live[$];
    int       i;
    int       pick;
    for (i = 0; i < SEM_SLOTS; i++) if (shadow.in_use[i]) live.push_back(i);
    pick = $urandom_range(0, 99);
    if (pick < w_create) r.act = ACT_CREATE;
    else if (pick < w_create + w_delete) r.act = ACT_DELETE;
    else if (pick < w_create + w_delete + w_pend) r.act = ACT_PEND;
    else r.act = ACT_POST;

    pick = $urandom_range(0, 19);
    if (pick == 0) r.handle = 8'($urandom_range(0, 255));
    else if (pick < 3 || live.size() == 0) r.handle = 8'($urandom_range(0, SEM_SLOTS - 1));
    else r.handle = 8'(live[$urandom_range(0, live.size() - 1)]);

    pick = $urandom_range(0, 9);
    if (pick == 0) r.init_count = 16'($urandom_range(0, 65535));
    else if (pick < 3) r.init_count = 16'($urandom_range(COUNT_LIMIT - 2, 65535));
    else r.init_count = 16'($urandom_range(0, 3));

    r.task_id = 5'($urandom_range(0, 31));

    pick = $urandom_range(0, 7);
    if (pick < 2) r.timeout = '0;
    else if (pick == 2) r.timeout = '1;
    else if (pick == 3) r.timeout = $urandom();
    else r.timeout = 32'($urandom_range(1, 100));

    r.in_interrupt = $urandom_range(0, 9) == 0;
    r.sched_locked = $urandom_range(0, 9) == 0;

    // Steer away from a post that would follow a never-written task link.
    if (r.act == ACT_POST && shadow.post_reads_unlinked(r.handle)) r.act = ACT_DELETE;
    return r;
  endfunction

  task automatic run_mix(int n, int w_create, int w_delete, int w_pend);
    repeat (n) send_req(random_req(w_create, w_delete, w_pend));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Bad handles, create limits, pend refusals, queue order, handle reuse
    send_req(make_req(ACT_POST,   8'd0,   16'd0,     5'd0,  32'd1,  1'b0, 1'b0));
    send_req(make_req(ACT_PEND,   8'd255, 16'hFFFF,  5'd31, '1,     1'b1, 1'b1));
    send_req(make_req(ACT_DELETE, 8'd16,  16'd0,     5'd0,  32'd0,  1'b0, 1'b0));
    send_req(make_req(ACT_CREATE, 8'd255, 16'hFFFF,  5'd31, '1,     1'b1, 1'b1));
    send_req(make_req(ACT_CREATE, 8'd0,   16'(COUNT_LIMIT), 5'd0, 32'd0, 1'b0, 1'b0));
    send_req(make_req(ACT_POST,   8'd0,   16'd0,     5'd0,  32'd0,  1'b0, 1'b0));
    send_req(make_req(ACT_PEND,   8'd0,   16'd0,     5'd1,  32'd0,  1'b0, 1'b0));
    send_req(make_req(ACT_POST,   8'd0,   16'd0,     5'd0,  32'd0,  1'b0, 1'b0));
    send_req(make_req(ACT_CREATE, 8'd0,   16'd0,     5'd0,  32'd0,  1'b0, 1'b0));
    send_req(make_req(ACT_PEND,   8'd1,   16'd0,     5'd2,  32'd0,  1'b1, 1'b1));
    send_req(make_req(ACT_PEND,   8'd1,   16'd0,     5'd2,  32'd5,  1'b1, 1'b1));
    send_req(make_req(ACT_PEND,   8'd1,   16'd0,     5'd2,  32'd5,  1'b0, 1'b1));
    send_req(make_req(ACT_PEND,   8'd1,   16'd0,     5'd3,  32'd7,  1'b0, 1'b0));
    send_req(make_req(ACT_PEND,   8'd1,   16'd0,     5'd31, '1,     1'b0, 1'b0));
    send_req(make_req(ACT_PEND,   8'd1,   16'd0,     5'd3,  32'd1,  1'b0, 1'b0));
    send_req(make_req(ACT_DELETE, 8'd1,   16'd0,     5'd0,  32'd0,  1'b0, 1'b0));
    send_req(make_req(ACT_POST,   8'd1,   16'd0,     5'd0,  32'd0,  1'b0, 1'b0));
    send_req(make_req(ACT_POST,   8'd1,   16'd0,     5'd0,  32'd0,  1'b0, 1'b0));
    send_req(make_req(ACT_POST,   8'd1,   16'd0,     5'd0,  32'd0,  1'b0, 1'b0));
    send_req(make_req(ACT_PEND,   8'd1,   16'd0,     5'd0,  32'd0,  1'b0, 1'b0));
    send_req(make_req(ACT_DELETE, 8'd1,   16'd0,     5'd0,  32'd0,  1'b0, 1'b0));
    send_req(make_req(ACT_CREATE, 8'd0,   16'd3,     5'd0,  32'd0,  1'b0, 1'b0));
    send_req(make_req(ACT_DELETE, 8'd0,   16'd0,     5'd0,  32'd0,  1'b0, 1'b0));
    send_req(make_req(ACT_DELETE, 8'd1,   16'd0,     5'd0,  32'd0,  1'b0, 1'b0));

    // Fill the pool until creates run out of handles
    run_mix(150, 40, 10, 25);
    drain_replies();
    run_mix(300, 10, 10, 45);
    idle_en = 1'b0;
    run_mix(150, 15, 35, 20);
    idle_en = 1'b1;
    run_mix(200, 25, 15, 30);
    idle_en = 1'b0;
    run_mix(100, 25, 25, 25);

    drain_replies();
    repeat (8) @(posedge clk);
    if (shadow.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
